// ----- hdl/lsru_pkg.sv -----
// Shared constants and operation codes for the lattice signature rounding unit.
package lsru_pkg;

    localparam int COEF_W    = 23;
    localparam int DROP_BITS = 13;

    // Operation codes carried on the func field.
    localparam logic [1:0] FUNC_POWER2ROUND = 2'd0;
    localparam logic [1:0] FUNC_DECOMPOSE   = 2'd1;
    localparam logic [1:0] FUNC_MAKE_HINT   = 2'd2;
    localparam logic [1:0] FUNC_USE_HINT    = 2'd3;

    localparam logic [COEF_W-1:0]    Q_MOD        = 23'd8380417;
    localparam logic [COEF_W-1:0]    MH_LOW_BOUND = 23'd95232;
    localparam logic [COEF_W-1:0]    MH_UP_BOUND  = 23'd8285185;
    localparam logic [DROP_BITS-1:0] P2R_HALF     = 13'd4096;
    localparam logic [13:0]          GAMMA_MUL    = 14'd11275;
    localparam logic [30:0]          ROUND_ADD    = 31'd8388608;
    localparam logic [17:0]          GAMMA2X2     = 18'd190464;
    localparam logic [5:0]           TOP_HIGH     = 6'd43;
    localparam logic signed [24:0]   HALF_Q_S     = 25'sd4190208;
    localparam logic signed [24:0]   Q_MOD_S      = 25'sd8380417;

endpackage

// ----- hdl/lattice_signature_rounding_unit.sv -----
// Four-stage pipelined rounding unit: power2round, decompose, make hint and use hint.
// Each item is registered in turn by the stage 1, 2 and 3 registers and then the output registers.
// Throughput: one item per cycle; busy is never raised, as nothing in the pipeline waits.
// The longest stage holds the 17 by 14 bit multiply that estimates the decompose high part.
// Reset is synchronous and active low; it clears the stage valid bits and the result strobe.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module lattice_signature_rounding_unit
    import lsru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [22:0]        i_value,
    input  logic [22:0]        i_low_in,
    input  logic               i_hint,
    output logic               o_valid,
    output logic [9:0]         o_high,
    output logic signed [17:0] o_low,
    output logic               o_hint_out
);

    // Stage 1: reduction and make-hint bound checks.
    logic              r_v1, r_hint1, r_hb1;
    logic [1:0]        r_func1;
    logic [22:0]       r_a1;
    logic [22:0]       n_a1;
    logic              n_hb1;

    // Stage 2: power2round split and decompose product.
    logic              r_v2, r_hint2, r_hb2;
    logic [1:0]        r_func2;
    logic [22:0]       r_a2;
    logic [9:0]        r_hp2;
    logic signed [17:0] r_lp2;
    logic [30:0]       r_prod2;
    logic [23:0]       n_sum2;
    logic [9:0]        n_hp2;
    logic signed [17:0] n_lp2;

    // Stage 3: decompose high part and raw low part.
    logic              r_v3, r_hint3, r_hb3;
    logic [1:0]        r_func3;
    logic [9:0]        r_hp3;
    logic signed [17:0] r_lp3;
    logic [5:0]        r_hg3;
    logic signed [24:0] r_lraw3;
    logic [30:0]       n_rnd3;
    logic [6:0]        n_hfull3;
    logic [5:0]        n_hg3;
    logic [23:0]       n_hmul3;

    // Stage 4: centring, hint correction and result selection.
    logic              r_vo;
    logic [9:0]        r_high;
    logic signed [17:0] r_low;
    logic              r_hb;
    logic signed [24:0] n_lc;
    logic [5:0]        n_hu;
    logic [9:0]        n_high;
    logic signed [17:0] n_low;
    logic              n_hb;

    assign busy = 1'b0;

    always_comb begin
        n_a1 = (i_value >= Q_MOD) ? i_value - Q_MOD : i_value;
        // Make hint is quiet for low parts at or below the lower bound or above the upper bound,
        // or on the upper edge with a zero input value.
        n_hb1 = !((i_low_in <= MH_LOW_BOUND) || (i_low_in > MH_UP_BOUND) ||
                  ((i_low_in == MH_UP_BOUND) && (i_value == '0)));
    end

    always_comb begin
        n_sum2 = {1'b0, r_a1} + 24'd127;
        if (r_a1[DROP_BITS-1:0] > P2R_HALF) begin
            n_hp2 = r_a1[COEF_W-1:DROP_BITS] + 10'd1;
            n_lp2 = $signed({5'b0, r_a1[DROP_BITS-1:0]}) - 18'sd8192;
        end else begin
            n_hp2 = r_a1[COEF_W-1:DROP_BITS];
            n_lp2 = $signed({5'b0, r_a1[DROP_BITS-1:0]});
        end
    end

    always_comb begin
        n_rnd3   = r_prod2 + ROUND_ADD;
        n_hfull3 = n_rnd3[30:24];
        n_hg3    = (n_hfull3 > {1'b0, TOP_HIGH}) ? 6'd0 : n_hfull3[5:0];
        n_hmul3  = 24'(n_hg3) * 24'(GAMMA2X2);
    end

    always_comb begin
        n_lc = (r_lraw3 > HALF_Q_S) ? r_lraw3 - Q_MOD_S : r_lraw3;
        n_hu = r_hg3;
        if (r_hint3) begin
            if (n_lc > 25'sd0) begin
                n_hu = (r_hg3 == TOP_HIGH) ? 6'd0 : r_hg3 + 6'd1;
            end else begin
                n_hu = (r_hg3 == 6'd0) ? TOP_HIGH : r_hg3 - 6'd1;
            end
        end
        n_high = '0;
        n_low  = '0;
        n_hb   = 1'b0;
        case (r_func3)
            FUNC_POWER2ROUND: begin
                n_high = r_hp3;
                n_low  = r_lp3;
            end
            FUNC_DECOMPOSE: begin
                n_high = {4'b0, r_hg3};
                n_low  = n_lc[17:0];
            end
            FUNC_MAKE_HINT: begin
                n_hb = r_hb3;
            end
            default: begin
                n_high = {4'b0, n_hu};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func1 <= i_func;
        r_a1    <= n_a1;
        r_hint1 <= i_hint;
        r_hb1   <= n_hb1;

        r_func2 <= r_func1;
        r_a2    <= r_a1;
        r_hint2 <= r_hint1;
        r_hb2   <= r_hb1;
        r_hp2   <= n_hp2;
        r_lp2   <= n_lp2;
        r_prod2 <= 31'(n_sum2[23:7]) * 31'(GAMMA_MUL);

        r_func3 <= r_func2;
        r_hint3 <= r_hint2;
        r_hb3   <= r_hb2;
        r_hp3   <= r_hp2;
        r_lp3   <= r_lp2;
        r_hg3   <= n_hg3;
        r_lraw3 <= $signed({2'b0, r_a2}) - $signed({1'b0, n_hmul3});

        r_high  <= n_high;
        r_low   <= n_low;
        r_hb    <= n_hb;
    end

    assign o_valid    = r_vo;
    assign o_high     = r_high;
    assign o_low      = r_low;
    assign o_hint_out = r_hb;

endmodule

// ----- hdl/lsru_checker.sv -----
// Port-level checker for the rounding unit, bound to the top level.
module lsru_checker
    import lsru_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_func,
    input logic               o_valid,
    input logic [9:0]         o_high,
    input logic signed [17:0] o_low,
    input logic               o_hint_out
);

    // Every accepted item yields its result on the outputs with the valid strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("accepted item gave no result after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result strobe without an accepted item");

    a_make_hint_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_func, 4) == FUNC_MAKE_HINT) |-> (o_high == '0 && o_low == '0))
        else $error("make hint result carries a high or low part");

    a_decompose_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_func, 4) == FUNC_DECOMPOSE || $past(i_func, 4) == FUNC_USE_HINT))
        |-> (o_high <= {4'b0, TOP_HIGH} && !o_hint_out))
        else $error("decomposed high part out of range or stray hint bit");

endmodule

bind lattice_signature_rounding_unit lsru_checker u_lsru_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_func     (i_func),
    .o_valid    (o_valid),
    .o_high     (o_high),
    .o_low      (o_low),
    .o_hint_out (o_hint_out)
);
